### design/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OKQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OKQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OKQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define OKQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/okq_pkg.sv
package okq_pkg;

  localparam int LFB       = 14;
  localparam int PAL_DEPTH = 32;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_OPAQUE = 2'd2
  } okq_status_e;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } okq_side_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [IDX_W-1:0] idx;
    okq_status_e      status;
  } okq_res_t;

  typedef logic [31:0] lin_tab_t [256];
  typedef longint coef_tab_t [18];

  // LMS rows, then Lab rows, scaled by 1e10
  localparam longint CoefE10 [18] = '{
    64'sd4122214708,  64'sd5363325363,   64'sd514459929,
    64'sd2119034982,  64'sd6806995451,   64'sd1073969566,
    64'sd883024619,   64'sd2817188376,   64'sd6299787005,
    64'sd2104542553,  64'sd7936177850,   -64'sd40720468,
    64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
    64'sd259040371,   64'sd7827717662,   -64'sd8086757660
  };

  function automatic coef_tab_t coef_table(int f);
    coef_tab_t t;
    longint    mag;
    longint    q;
    for (int k = 0; k < 18; k++) begin
      mag  = (CoefE10[k] < 0) ? -CoefE10[k] : CoefE10[k];
      q    = (mag * (longint'(1) << f) + 64'sd5000000000) / 64'sd10000000000;
      t[k] = (CoefE10[k] < 0) ? -q : q;
    end
    return t;
  endfunction

  function automatic logic [63:0] mulw(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // sRGB decode in Q.30: x^2.4 as x^2 * x^0.4, fifth root by bisection
  function automatic logic [31:0] lin_entry(int c, int f);
    logic [63:0] lin;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y2;
    logic [63:0] y4;
    if (c <= 10) begin
      lin = (64'(c) * 64'd5 * (64'd1 << 30) + 64'd8236) / 64'd16473;
    end else begin
      x  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
      x2 = mulw(x, x);
      lo = 64'd0;
      hi = 64'd1 << 30;
      for (int it = 0; it < 40; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          y2  = mulw(mid, mid);
          y4  = mulw(y2, y2);
          if (mulw(y4, mid) <= x2) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      lin = mulw(x2, lo);
    end
    return 32'((lin + (64'd1 << (29 - f))) >> (30 - f));
  endfunction

  function automatic lin_tab_t lin_table(int f);
    lin_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = lin_entry(i, f);
    return t;
  endfunction

endpackage

### design/okq_lab_conv.sv
module okq_lab_conv import okq_pkg::*; #(
  parameter int F = LFB
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  okq_side_t           side_i,
  output logic                valid_o,
  output okq_side_t           side_o,
  output logic signed [F+1:0] lab_l_o,
  output logic signed [F+1:0] lab_a_o,
  output logic signed [F+1:0] lab_b_o
);

  localparam int RW  = F + 1;
  localparam int V2W = 2 * F + 3;
  localparam int V3W = 3 * F + 4;
  localparam int CW  = F + 3;
  localparam int AW  = 2 * F + 6;
  localparam int LW  = F + 2;
  localparam int NS  = F + 4;

  localparam lin_tab_t  LinTab = lin_table(F);
  localparam coef_tab_t CoefQ  = coef_table(F);

  logic [NS-1:0] vld_q;
  okq_side_t     side_q [NS];
  logic [RW-1:0] lin_q [3];

  // cube root state per stage: y, y^2, y^3 and target v << 2F
  logic [RW-1:0]  y_q  [3][F+2];
  logic [V2W-1:0] y2_q [3][F+2];
  logic [V3W-1:0] y3_q [3][F+2];
  logic [V3W-1:0] tg_q [3][F+2];

  logic signed [LW-1:0] lab_q [3];

  logic signed [AW-1:0] lms_acc [3];
  logic [AW-1:0]        lms_rnd [3];
  logic [AW-1:0]        lms_v   [3];
  logic [V3W-1:0]       tg_d    [3];
  logic signed [AW-1:0] lab_acc [3];
  logic [AW-1:0]        lab_mag [3];
  logic [AW-1:0]        lab_rq  [3];
  logic signed [LW-1:0] lab_d   [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lms_acc[ch] = '0;
      lab_acc[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        lms_acc[ch] = lms_acc[ch] + AW'(signed'(CW'(CoefQ[3 * ch + k])))
                      * AW'(signed'({1'b0, lin_q[k]}));
        lab_acc[ch] = lab_acc[ch] + AW'(signed'(CW'(CoefQ[9 + 3 * ch + k])))
                      * AW'(signed'({1'b0, y_q[k][F+1]}));
      end
      // clamp negative, round to Q.F, cap at one
      lms_rnd[ch] = lms_acc[ch][AW-1] ? '0
                  : (AW'(unsigned'(lms_acc[ch])) + (AW'(1) << (F - 1)));
      lms_v[ch]   = lms_rnd[ch] >> F;
      if (lms_v[ch] > (AW'(1) << F)) tg_d[ch] = V3W'(1) << (3 * F);
      else tg_d[ch] = V3W'(lms_v[ch]) << (2 * F);

      // round half away from zero, saturate to Q2.F
      lab_mag[ch] = lab_acc[ch][AW-1] ? (AW'(0) - AW'(unsigned'(lab_acc[ch])))
                                      : AW'(unsigned'(lab_acc[ch]));
      lab_rq[ch]  = (lab_mag[ch] + (AW'(1) << (F - 1))) >> F;
      if (lab_acc[ch][AW-1]) begin
        lab_d[ch] = (lab_rq[ch] > (AW'(1) << (F + 1))) ? {1'b1, {(LW-1){1'b0}}}
                  : LW'(AW'(0) - lab_rq[ch]);
      end else begin
        lab_d[ch] = (lab_rq[ch] > ((AW'(1) << (F + 1)) - AW'(1))) ? {1'b0, {(LW-1){1'b1}}}
                  : LW'(lab_rq[ch]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NS; s++) side_q[s] <= side_q[s-1];
      lin_q[0] <= RW'(LinTab[side_i.red]);
      lin_q[1] <= RW'(LinTab[side_i.green]);
      lin_q[2] <= RW'(LinTab[side_i.blue]);
      for (int ch = 0; ch < 3; ch++) begin
        y_q[ch][0]  <= '0;
        y2_q[ch][0] <= '0;
        y3_q[ch][0] <= '0;
        tg_q[ch][0] <= tg_d[ch];
        lab_q[ch]   <= lab_d[ch];
      end
    end
  end

  // one root bit per stage; cand^3 and cand^2 built from y, y^2, y^3 by shifts
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    for (genvar j = 0; j <= F; j++) begin : g_bit
      localparam int B = F - j;
      logic [V3W-1:0] c3;
      logic [V2W-1:0] c2;
      logic           take;

      assign c3 = y3_q[ch][j]
                + ((V3W'(y2_q[ch][j]) * V3W'(3)) << B)
                + ((V3W'(y_q[ch][j]) * V3W'(3)) << (2 * B))
                + (V3W'(1) << (3 * B));
      assign c2 = y2_q[ch][j] + (V2W'(y_q[ch][j]) << (B + 1)) + (V2W'(1) << (2 * B));
      assign take = (c3 <= tg_q[ch][j]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[ch][j+1]  <= take ? (y_q[ch][j] | (RW'(1) << B)) : y_q[ch][j];
          y2_q[ch][j+1] <= take ? c2 : y2_q[ch][j];
          y3_q[ch][j+1] <= take ? c3 : y3_q[ch][j];
          tg_q[ch][j+1] <= tg_q[ch][j];
        end
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign lab_l_o = lab_q[0];
  assign lab_a_o = lab_q[1];
  assign lab_b_o = lab_q[2];

endmodule

### design/okq_search.sv
module okq_search import okq_pkg::*; #(
  parameter int F  = LFB,
  parameter int PD = PAL_DEPTH,
  parameter int NP = 1 << $clog2(PD)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                valid_i,
  input  okq_side_t           side_i,
  input  logic signed [F+1:0] lab_l_i,
  input  logic signed [F+1:0] lab_a_i,
  input  logic signed [F+1:0] lab_b_i,
  input  logic [CNT_W-1:0]    count_i,
  output logic [NP-1:0]       srch_o,
  output logic [2*F+5:0]      dist_o [NP],
  output logic [23:0]         rgb_o [NP],
  output okq_status_e         status_o
);

  localparam int LW  = F + 2;
  localparam int SW  = LW + 1;
  localparam int DW  = 2 * F + 6;
  localparam int PIW = (PD > 1) ? $clog2(PD) : 1;

  logic signed [LW-1:0] pal_l [PD];
  logic signed [LW-1:0] pal_a [PD];
  logic signed [LW-1:0] pal_b [PD];
  logic [23:0]          pal_rgb [PD];
  logic                 pal_op [PD];

  logic           bad;
  logic           wr_en;
  logic [PIW-1:0] wr_addr;

  // distance stage: all palette reads and writes happen here, in item order
  for (genvar i = 0; i < NP; i++) begin : g_dist
    if (i < PD) begin : g_live
      logic signed [SW-1:0]   dl, da, db;
      logic signed [2*SW-1:0] ql, qa, qb;
      assign dl = SW'(lab_l_i) - SW'(pal_l[i]);
      assign da = SW'(lab_a_i) - SW'(pal_a[i]);
      assign db = SW'(lab_b_i) - SW'(pal_b[i]);
      assign ql = dl * dl;
      assign qa = da * da;
      assign qb = db * db;
      assign dist_o[i] = DW'(unsigned'(ql)) + DW'(unsigned'(qa)) + DW'(unsigned'(qb));
      assign srch_o[i] = (32'(i) < 32'(count_i));
      assign rgb_o[i]  = pal_rgb[i];
    end else begin : g_pad
      assign dist_o[i] = '0;
      assign srch_o[i] = 1'b0;
      assign rgb_o[i]  = '0;
    end
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < PD; i++) bad = bad | (srch_o[i] & ~pal_op[i]);
    if (count_i == '0) status_o = ST_EMPTY;
    else if (bad) status_o = ST_OPAQUE;
    else status_o = ST_OK;
  end

  assign wr_en   = en_i && valid_i && (side_i.func == FUNC_WRITE)
                   && (32'(side_i.idx) < 32'(PD));
  assign wr_addr = PIW'(side_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_l[wr_addr]   <= lab_l_i;
      pal_a[wr_addr]   <= lab_a_i;
      pal_b[wr_addr]   <= lab_b_i;
      pal_rgb[wr_addr] <= {side_i.red, side_i.green, side_i.blue};
      pal_op[wr_addr]  <= (side_i.alpha == 8'hff);
    end
  end

endmodule

### design/okq_search_core.sv
module okq_search_core import okq_pkg::*; #(
  parameter int F  = LFB,
  parameter int PD = PAL_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  okq_side_t           side_i,
  input  logic signed [F+1:0] lab_l_i,
  input  logic signed [F+1:0] lab_a_i,
  input  logic signed [F+1:0] lab_b_i,
  input  logic [CNT_W-1:0]    count_i,
  output logic                valid_o,
  output okq_res_t            res_o
);

  localparam int DW  = 2 * F + 6;
  localparam int L   = $clog2(PD);
  localparam int NP  = 1 << L;
  localparam int TW  = (L > 0) ? L : 1;

  typedef struct packed {
    logic [7:0]  alpha;
    okq_status_e status;
    logic        zero;
  } okq_meta_t;

  logic          tv_q   [L+1][NP];
  logic [DW-1:0] td_q   [L+1][NP];
  logic [TW-1:0] ti_q   [L+1][NP];
  logic [23:0]   trgb_q [L+1][NP];

  logic [L:0]  mv_q;
  okq_meta_t   meta_q [L+1];
  okq_meta_t   meta_d;

  logic [NP-1:0]  srch;
  logic [DW-1:0]  ent_dist [NP];
  logic [23:0]    ergb [NP];
  okq_status_e    st_d;

  okq_search #(.F(F), .PD(PD), .NP(NP)) u_pal (
    .clk_i    (clk_i),
    .en_i     (en_i),
    .valid_i  (valid_i),
    .side_i   (side_i),
    .lab_l_i  (lab_l_i),
    .lab_a_i  (lab_a_i),
    .lab_b_i  (lab_b_i),
    .count_i  (count_i),
    .srch_o   (srch),
    .dist_o   (ent_dist),
    .rgb_o    (ergb),
    .status_o (st_d)
  );

  always_comb begin
    meta_d.alpha  = side_i.alpha;
    meta_d.status = st_d;
    meta_d.zero   = (st_d != ST_OK) || (side_i.alpha == 8'd0);
  end

  // only pixel requests carry a valid bit past this point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
    end else if (en_i) begin
      mv_q[0] <= valid_i && (side_i.func == FUNC_PIXEL);
      for (int l = 1; l <= L; l++) mv_q[l] <= mv_q[l-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_d;
      for (int l = 1; l <= L; l++) meta_q[l] <= meta_q[l-1];
      for (int i = 0; i < NP; i++) begin
        tv_q[0][i]   <= srch[i];
        td_q[0][i]   <= ent_dist[i];
        ti_q[0][i]   <= TW'(i);
        trgb_q[0][i] <= ergb[i];
      end
    end
  end

  // min tree; left child wins ties, so the lower index is kept
  for (genvar l = 1; l <= L; l++) begin : g_lvl
    for (genvar n = 0; n < (NP >> l); n++) begin : g_node
      logic pr;
      assign pr = tv_q[l-1][2*n+1]
                  && (!tv_q[l-1][2*n] || (td_q[l-1][2*n+1] < td_q[l-1][2*n]));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tv_q[l][n]   <= tv_q[l-1][2*n] | tv_q[l-1][2*n+1];
          td_q[l][n]   <= pr ? td_q[l-1][2*n+1]   : td_q[l-1][2*n];
          ti_q[l][n]   <= pr ? ti_q[l-1][2*n+1]   : ti_q[l-1][2*n];
          trgb_q[l][n] <= pr ? trgb_q[l-1][2*n+1] : trgb_q[l-1][2*n];
        end
      end
    end
  end

  always_comb begin
    res_o.alpha  = meta_q[L].alpha;
    res_o.status = meta_q[L].status;
    if (meta_q[L].zero) begin
      res_o.red   = '0;
      res_o.green = '0;
      res_o.blue  = '0;
      res_o.idx   = '0;
    end else begin
      res_o.red   = trgb_q[L][0][23:16];
      res_o.green = trgb_q[L][0][15:8];
      res_o.blue  = trgb_q[L][0][7:0];
      res_o.idx   = IDX_W'(ti_q[L][0]);
    end
  end

  assign valid_o = mv_q[L];

endmodule

### design/oklab_nearest_palette_quantizer.sv
// Oklab nearest-color palette quantizer.
// One input stream carries two kinds of request, told apart by tuser: a
// palette write (slot, sRGB color, alpha 255 for opaque) and a pixel.
// Both run through the same sRGB -> Oklab pipeline; a write lands in the
// palette registers at the distance stage and yields no result, a pixel
// yields one result: nearest entry color, its index, the pixel alpha and
// a status (palette empty, or a searched entry not opaque).
// cfg_we_i/cfg_wdata_i set the number of entries searched; write it only
// while no request is in flight.
// Throughput is one request per cycle while the receiver does not stall:
// the cube root resolves one bit per stage and the entry compare is a
// registered tree, one level per stage.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops in the same cycle; nothing is dropped or repeated.
// Reset clears valid bits and the entry count; palette slots hold no
// defined value until written.
`include "assert_macros.svh"

module oklab_nearest_palette_quantizer import okq_pkg::*; #(
  parameter int PALETTE_DEPTH = PAL_DEPTH,
  parameter int LAB_FRAC_BITS = LFB
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[4:0], red[12:5], green[20:13], blue[28:21], alpha[36:29]
  input  logic [39:0]      s_axis_tdata,
  // func[0]
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
  // best_index[36:32], status[38:37]
  output logic [39:0]      m_axis_tdata
);

  localparam int F = LAB_FRAC_BITS;

  logic [CNT_W-1:0] count_q;
  logic             adv;
  okq_side_t        side_in;
  logic             cv_valid;
  okq_side_t        cv_side;
  logic signed [F+1:0] cv_l, cv_a, cv_b;
  logic             sr_valid;
  okq_res_t         sr_res;
  logic             out_vq;
  okq_res_t         out_q;

  assign adv           = !out_vq || m_axis_tready;
  assign s_axis_tready = adv;

  assign side_in.func  = s_axis_tuser[0];
  assign side_in.idx   = s_axis_tdata[4:0];
  assign side_in.red   = s_axis_tdata[12:5];
  assign side_in.green = s_axis_tdata[20:13];
  assign side_in.blue  = s_axis_tdata[28:21];
  assign side_in.alpha = s_axis_tdata[36:29];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  okq_lab_conv #(.F(F)) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .side_i  (side_in),
    .valid_o (cv_valid),
    .side_o  (cv_side),
    .lab_l_o (cv_l),
    .lab_a_o (cv_a),
    .lab_b_o (cv_b)
  );

  okq_search_core #(.F(F), .PD(PALETTE_DEPTH)) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cv_valid),
    .side_i  (cv_side),
    .lab_l_i (cv_l),
    .lab_a_i (cv_a),
    .lab_b_i (cv_b),
    .count_i (count_q),
    .valid_o (sr_valid),
    .res_o   (sr_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= sr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= sr_res;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = {1'b0, out_q.status, out_q.idx, out_q.alpha,
                          out_q.blue, out_q.green, out_q.red};

  `OKQ_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, out_vq && !m_axis_tready, !s_axis_tready)
  `OKQ_ASSERT_IMPL(a_error_zeroes, clk_i, rst_ni, out_vq && (out_q.status != ST_OK), (out_q.idx == '0) && (out_q.red == '0) && (out_q.green == '0) && (out_q.blue == '0))
  `OKQ_ASSERT_IMPL(a_empty_needs_zero_count, clk_i, rst_ni, out_vq && (out_q.status == ST_EMPTY), count_q == '0)

endmodule

### verif/oklab_nearest_palette_quantizer_test.sv
module oklab_nearest_palette_quantizer_test;
  import okq_pkg::*;

  typedef struct {
    logic             func;
    logic [IDX_W-1:0] slot;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } request_t;

  typedef struct {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [IDX_W-1:0] idx;
    okq_status_e      status;
  } quant_t;

  localparam int FRAC     = 14;
  localparam int DRAIN    = 40;
  localparam int RAND_REQ = 1650;

  // LMS rows, then Lab rows, scaled by 1e10
  localparam longint MatE10 [18] = '{
    64'sd4122214708,  64'sd5363325363,   64'sd514459929,
    64'sd2119034982,  64'sd6806995451,   64'sd1073969566,
    64'sd883024619,   64'sd2817188376,   64'sd6299787005,
    64'sd2104542553,  64'sd7936177850,   -64'sd40720468,
    64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
    64'sd259040371,   64'sd7827717662,   -64'sd8086757660
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata = '0;
  logic [0:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;

  oklab_nearest_palette_quantizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  request_t pending_q[$];
  quant_t   quant_q[$];
  request_t on_bus;
  logic     bus_taken = 1'b0;
  bit       calm = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       errors = 0;
  int       n_pixels = 0, n_writes = 0, n_results = 0;
  int       n_empty = 0, n_opaque_err = 0, n_clear = 0;

  // predictor state
  longint           decode_rom [256];
  longint           mat_q [18];
  logic [CNT_W-1:0] search_count = '0;
  logic [23:0]      pal_rgb [PAL_DEPTH];
  longint           pal_lab [PAL_DEPTH][3];
  bit               pal_opaque [PAL_DEPTH];

  function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint srgb_decode(int c);
    longint unsigned lin, x, x2, lo, hi, mid, p;
    if (c <= 10) begin
      lin = (longint'(c) * 5 * (64'd1 << 30) + 8236) / 16473;
    end else begin
      x  = ((longint'(1000 * c + 14025) << 30) + 134512) / 269025;
      x2 = mul30(x, x);
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        p   = mul30(mul30(mul30(mid, mid), mul30(mid, mid)), mid);
        if (p <= x2) lo = mid;
        else hi = mid - 1;
      end
      lin = mul30(x2, lo);
    end
    return longint'((lin + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  function automatic longint cube_root(longint v);
    longint one, target, y, cand;
    one = longint'(1) << FRAC;
    if (v > one) v = one;
    target = v << (2 * FRAC);
    y = 0;
    for (int b = FRAC; b >= 0; b--) begin
      cand = y | (longint'(1) << b);
      if (cand <= one && cand * cand * cand <= target) y = cand;
    end
    return y;
  endfunction

  function automatic longint lab_round(longint acc);
    longint half, r, lim;
    half = longint'(1) << (FRAC - 1);
    lim  = longint'(1) << (FRAC + 1);
    if (acc >= 0) r = (acc + half) >>> FRAC;
    else r = -((-acc + half) >>> FRAC);
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  task automatic to_oklab(input logic [7:0] r, g, b, output longint lab[3]);
    longint lin[3], root[3], acc;
    lin[0] = decode_rom[r];
    lin[1] = decode_rom[g];
    lin[2] = decode_rom[b];
    for (int k = 0; k < 3; k++) begin
      acc = mat_q[3*k] * lin[0] + mat_q[3*k+1] * lin[1] + mat_q[3*k+2] * lin[2];
      if (acc < 0) acc = 0;
      root[k] = cube_root((acc + (longint'(1) << (FRAC - 1))) >>> FRAC);
    end
    for (int k = 0; k < 3; k++) begin
      acc = mat_q[9+3*k] * root[0] + mat_q[10+3*k] * root[1] + mat_q[11+3*k] * root[2];
      lab[k] = lab_round(acc);
    end
  endtask

  // applies one accepted request; pixels queue their nearest-entry result
  task automatic quantize(input request_t rq);
    quant_t q;
    longint px[3], d, best_d, diff;
    int     cnt;
    if (rq.func == FUNC_WRITE) begin
      n_writes++;
      pal_rgb[rq.slot] = {rq.red, rq.green, rq.blue};
      to_oklab(rq.red, rq.green, rq.blue, px);
      for (int k = 0; k < 3; k++) pal_lab[rq.slot][k] = px[k];
      pal_opaque[rq.slot] = (rq.alpha == 8'd255);
      return;
    end
    n_pixels++;
    cnt = (search_count > PAL_DEPTH) ? PAL_DEPTH : int'(search_count);
    q.red = '0; q.green = '0; q.blue = '0; q.idx = '0;
    q.alpha = rq.alpha;
    q.status = ST_OK;
    for (int i = 0; i < cnt; i++) if (!pal_opaque[i]) q.status = ST_OPAQUE;
    if (cnt == 0) q.status = ST_EMPTY;
    if (q.status == ST_EMPTY) n_empty++;
    else if (q.status == ST_OPAQUE) n_opaque_err++;
    else if (rq.alpha == 8'd0) n_clear++;
    if (q.status == ST_OK && rq.alpha != 8'd0) begin
      to_oklab(rq.red, rq.green, rq.blue, px);
      best_d = 0;
      for (int i = 0; i < cnt; i++) begin
        d = 0;
        for (int k = 0; k < 3; k++) begin
          diff = px[k] - pal_lab[i][k];
          d += diff * diff;
        end
        if (i == 0 || d < best_d) begin
          best_d = d;
          q.idx = IDX_W'(i);
        end
      end
      {q.red, q.green, q.blue} = pal_rgb[q.idx];
    end
    quant_q = {quant_q, q};
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver and output ready driver
  always @(negedge clk_i) begin
    logic     nv;
    request_t nr;
    nv = s_axis_tvalid && !bus_taken;
    nr = on_bus;
    if (!nv) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0 && rst_ni) begin
        nr = pending_q.pop_front();
        nv = 1'b1;
        gap_left <= pick_gap();
      end
    end
    on_bus = nr;
    s_axis_tvalid <= nv;
    s_axis_tuser  <= nr.func;
    s_axis_tdata  <= {3'b0, nr.alpha, nr.blue, nr.green, nr.red, nr.slot};
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= rst_ni;
    end
    if ($urandom_range(199) == 0) calm <= !calm;
  end

  // acceptance and result monitor
  always @(posedge clk_i) begin
    quant_t want;
    bus_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      quantize(on_bus);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (quant_q.size() == 0) begin
        report("result with none expected, data", m_axis_tdata, 0);
      end else begin
        want = quant_q.pop_front();
        if (m_axis_tdata[7:0] !== want.red) report("out_red", m_axis_tdata[7:0], want.red);
        if (m_axis_tdata[15:8] !== want.green)
          report("out_green", m_axis_tdata[15:8], want.green);
        if (m_axis_tdata[23:16] !== want.blue)
          report("out_blue", m_axis_tdata[23:16], want.blue);
        if (m_axis_tdata[31:24] !== want.alpha)
          report("out_alpha", m_axis_tdata[31:24], want.alpha);
        if (m_axis_tdata[36:32] !== want.idx)
          report("best_index", m_axis_tdata[36:32], want.idx);
        if (m_axis_tdata[38:37] !== want.status)
          report("status", m_axis_tdata[38:37], want.status);
      end
    end
  end

  task automatic push_req(input logic func, input int slot, input logic [7:0] r, g, b, a);
    request_t rq;
    rq.func = func;
    rq.slot = IDX_W'(slot);
    rq.red = r; rq.green = g; rq.blue = b; rq.alpha = a;
    pending_q = {pending_q, rq};
  endtask

  task automatic drain_all();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || s_axis_tvalid || quant_q.size() > 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_count(input int n);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CNT_W'(n);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    search_count = CNT_W'(n);
  endtask

  task automatic random_burst(input int n);
    logic [7:0] c[3];
    int         s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        // mostly opaque rewrites; a rare translucent one trips the entry check
        push_req(FUNC_WRITE, $urandom_range(31), 8'($urandom), 8'($urandom), 8'($urandom),
                 ($urandom_range(99) < 6) ? 8'($urandom_range(254)) : 8'd255);
      end else begin
        if ($urandom_range(99) < 40) begin
          // near an existing entry, to stress close distances
          s = $urandom_range(31);
          for (int k = 0; k < 3; k++)
            c[k] = pal_rgb[s][23-8*k -: 8] + 8'($urandom_range(6)) - 8'd3;
        end else begin
          for (int k = 0; k < 3; k++) c[k] = 8'($urandom);
        end
        push_req(FUNC_PIXEL, $urandom_range(31), c[0], c[1], c[2],
                 ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom));
      end
    end
  endtask

  initial begin
    int plan[8] = '{32, 1, 63, 40, 0, 2, 17, 32};
    for (int i = 0; i < 256; i++) decode_rom[i] = srgb_decode(i);
    for (int i = 0; i < 18; i++) begin
      mat_q[i] = ((MatE10[i] < 0 ? -MatE10[i] : MatE10[i]) * (longint'(1) << FRAC)
                  + 64'sd5000000000) / 64'sd10000000000;
      if (MatE10[i] < 0) mat_q[i] = -mat_q[i];
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty palette, then fill every slot opaque
    push_req(FUNC_PIXEL, 0, 8'd10, 8'd20, 8'd30, 8'd77);
    push_req(FUNC_WRITE, 0, 8'd0, 8'd0, 8'd0, 8'd255);
    push_req(FUNC_WRITE, 1, 8'd255, 8'd255, 8'd255, 8'd255);
    push_req(FUNC_WRITE, 2, 8'd255, 8'd0, 8'd0, 8'd255);
    push_req(FUNC_WRITE, 3, 8'd0, 8'd255, 8'd0, 8'd255);
    push_req(FUNC_WRITE, 4, 8'd0, 8'd0, 8'd255, 8'd255);
    push_req(FUNC_WRITE, 5, 8'd0, 8'd255, 8'd0, 8'd255);  // tie with slot 3
    for (int i = 6; i < 32; i++)
      push_req(FUNC_WRITE, i, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
    push_req(FUNC_PIXEL, 31, 8'd255, 8'd255, 8'd255, 8'd255);
    drain_all();

    set_count(32);
    push_req(FUNC_PIXEL, 0, 8'd0, 8'd0, 8'd0, 8'd255);
    push_req(FUNC_PIXEL, 0, 8'd255, 8'd255, 8'd255, 8'd1);
    push_req(FUNC_PIXEL, 0, 8'd0, 8'd250, 8'd5, 8'd128);
    push_req(FUNC_PIXEL, 0, 8'd9, 8'd10, 8'd11, 8'd0);
    push_req(FUNC_PIXEL, 0, 8'd200, 8'd0, 8'd0, 8'd255);
    push_req(FUNC_PIXEL, 0, 8'd3, 8'd7, 8'd240, 8'd255);
    push_req(FUNC_WRITE, 7, 8'd1, 8'd2, 8'd3, 8'd254);
    push_req(FUNC_PIXEL, 0, 8'd100, 8'd100, 8'd100, 8'd200);
    push_req(FUNC_PIXEL, 0, 8'd100, 8'd100, 8'd100, 8'd0);
    push_req(FUNC_WRITE, 7, 8'd128, 8'd64, 8'd32, 8'd255);
    push_req(FUNC_PIXEL, 0, 8'd128, 8'd64, 8'd32, 8'd255);
    drain_all();

    foreach (plan[p]) begin
      set_count(plan[p] == 17 ? $urandom_range(2, 31) : plan[p]);
      random_burst(RAND_REQ / 8);
      drain_all();
    end

    $display("%0d pixels, %0d palette writes, %0d results checked", n_pixels, n_writes,
             n_results);
    $display("empty palette %0d, translucent entry %0d, transparent pixels %0d", n_empty,
             n_opaque_err, n_clear);
    if (errors == 0) begin
      $display("oklab_nearest_palette_quantizer: match");
    end else begin
      $display("oklab_nearest_palette_quantizer: mismatch");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("oklab_nearest_palette_quantizer: mismatch");
    $finish;
  end

endmodule
